/* sv/atlf_pkg.sv */
// Shared types and constants for the AT response line framer.
package atlf_pkg;

    localparam int LINE_BYTES = 64;
    localparam int ADDR_W     = $clog2(LINE_BYTES);

    typedef logic [ADDR_W-1:0] idx_t;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_T    = 8'h54;

    localparam logic KIND_AT  = 1'b0;
    localparam logic KIND_APP = 1'b1;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_GOT_A,
        FS_AT,
        FS_APP
    } frame_state_t;

    typedef struct packed {
        logic bank;
        idx_t len;
        logic kind;
    } line_cmd_t;

    typedef struct packed {
        logic       en;
        logic       bank;
        idx_t       addr;
        logic [7:0] data;
    } store_wr_t;

endpackage

/* sv/at_response_line_framer.sv */
// Top level of the AT response line framer.
//
// The input channel (in_valid, in_ready, rx_byte) takes one received serial
// byte per item. The output channel (out_valid, out_ready, line_byte,
// line_kind, last_of_line) gives one item per byte of a finished line.
// A CR or LF that ends a line queues the line for emission. Its command is
// registered in the queue, then its first byte is loaded into the output
// register; the rest follow one per cycle while out_ready stays high.
// The line store has two banks, so the next line is received while the
// previous one drains. When both banks hold finished lines, in_ready drops
// until the emitter loads the last byte of the older line into its output
// register, and rises in the following cycle.
// A stall on out_ready holds the current output item and pauses draining.
// Reset clears the framer to idle and empties the line queue; the store
// contents are not cleared.
module at_response_line_framer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] line_byte,
    output logic       line_kind,
    output logic       last_of_line
);
    import atlf_pkg::*;

    store_wr_t store_wr;
    line_cmd_t push_cmd;
    line_cmd_t head;
    logic      push;
    logic      pop;
    logic      head_valid;
    logic      q_full;
    logic      accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    atlf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .store_wr (store_wr),
        .push     (push),
        .cmd      (push_cmd)
    );

    atlf_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (head_valid),
        .full      (q_full)
    );

    atlf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .store_wr     (store_wr),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .line_byte    (line_byte),
        .line_kind    (line_kind),
        .last_of_line (last_of_line)
    );

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("line command pushed into a full queue");

    a_push_len: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_cmd.len != '0))
        else $error("empty line queued for emission");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("line command popped from an empty queue");

    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid && last_of_line))
        else $error("line finished without a last item");

endmodule

/* sv/atlf_front.sv */
// Line framing front end: classifies received bytes and fills the line store.
module atlf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    output atlf_pkg::store_wr_t store_wr,
    output logic                push,
    output atlf_pkg::line_cmd_t cmd
);
    import atlf_pkg::*;

    frame_state_t state_reg;
    frame_state_t state_next;
    idx_t         fill_reg;
    idx_t         fill_next;
    logic         bank_reg;
    logic         bank_next;
    logic         is_term;
    logic         line_full;

    assign is_term   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    assign line_full = (fill_reg == idx_t'(LINE_BYTES - 1));

    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            unique case (state_reg)
                FS_IDLE:
                begin
                    if (!is_term)
                    begin
                        if (rx_byte == CH_PLUS)
                        begin
                            state_next = FS_AT;
                        end
                        else if (rx_byte == CH_A)
                        begin
                            state_next = FS_GOT_A;
                        end
                        else
                        begin
                            state_next = FS_APP;
                        end
                    end
                end
                FS_GOT_A:
                begin
                    if ((rx_byte == CH_T) || (rx_byte == CH_PLUS))
                    begin
                        state_next = FS_AT;
                    end
                    else
                    begin
                        state_next = FS_IDLE;
                    end
                end
                FS_AT, FS_APP:
                begin
                    if (line_full || is_term)
                    begin
                        state_next = FS_IDLE;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        store_wr.en   = 1'b0;
        store_wr.bank = bank_reg;
        store_wr.addr = fill_reg;
        store_wr.data = rx_byte;
        push          = 1'b0;
        cmd.bank      = bank_reg;
        cmd.len       = fill_reg;
        cmd.kind      = (state_reg == FS_APP) ? KIND_APP : KIND_AT;
        fill_next     = fill_reg;
        bank_next     = bank_reg;
        if (accept)
        begin
            unique case (state_reg)
                FS_IDLE:
                begin
                    if (!is_term)
                    begin
                        store_wr.en   = 1'b1;
                        store_wr.addr = '0;
                        fill_next     = idx_t'(1);
                    end
                end
                FS_GOT_A:
                begin
                    if (rx_byte == CH_T)
                    begin
                        store_wr.en = 1'b1;
                        fill_next   = fill_reg + 1'b1;
                    end
                    else if (rx_byte == CH_PLUS)
                    begin
                        store_wr.en   = 1'b1;
                        store_wr.addr = '0;
                        fill_next     = idx_t'(1);
                    end
                    else
                    begin
                        fill_next = '0;
                    end
                end
                FS_AT, FS_APP:
                begin
                    if (line_full)
                    begin
                        fill_next = '0;
                    end
                    else if (is_term)
                    begin
                        push      = 1'b1;
                        fill_next = '0;
                        bank_next = ~bank_reg;
                    end
                    else
                    begin
                        store_wr.en = 1'b1;
                        fill_next   = fill_reg + 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            fill_reg  <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

/* sv/atlf_cmd_queue.sv */
// Two-entry queue of finished-line commands between front end and emitter.
module atlf_cmd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  atlf_pkg::line_cmd_t push_cmd,
    input  logic                pop,
    output atlf_pkg::line_cmd_t head,
    output logic                not_empty,
    output logic                full
);
    import atlf_pkg::*;

    line_cmd_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/atlf_back.sv */
// Line emitter: holds the two-bank line store and drains lines byte by byte.
module atlf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  atlf_pkg::store_wr_t store_wr,
    input  atlf_pkg::line_cmd_t head,
    input  logic                head_valid,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          line_byte,
    output logic                line_kind,
    output logic                last_of_line
);
    import atlf_pkg::*;

    logic [7:0] store_mem [2][LINE_BYTES];
    idx_t       idx_reg;
    idx_t       idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] line_byte_reg;
    logic       line_kind_reg;
    logic       last_reg;
    logic       load;
    logic       is_last;

    assign load    = head_valid && (!out_valid_reg || out_ready);
    assign is_last = (idx_reg == head.len - 1'b1);
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? '0 : idx_reg + 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            store_mem[store_wr.bank][store_wr.addr] <= store_wr.data;
        end
        if (load)
        begin
            line_byte_reg <= store_mem[head.bank][idx_reg];
            line_kind_reg <= head.kind;
            last_reg      <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign line_byte    = line_byte_reg;
    assign line_kind    = line_kind_reg;
    assign last_of_line = last_reg;

endmodule

/* tb/sv/tb_at_response_line_framer.sv */
// Self-checking testbench for the AT response line framer with its own line predictor.
module tb_at_response_line_framer;

    timeunit 1ns;
    timeprecision 1ps;

    import atlf_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 20;

    typedef struct {
        logic [7:0] data;
        logic       kind;
        logic       last;
    } line_item_t;

    typedef enum int {
        HEAD_AT,
        HEAD_PLUS,
        HEAD_A_PLUS,
        HEAD_APP,
        HEAD_A_JUNK
    } line_head_t;

    typedef enum int {
        TERM_CR,
        TERM_LF,
        TERM_CR_LF,
        TERM_LF_CR
    } line_term_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte      = 8'h00;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [7:0] line_byte;
    logic       line_kind;
    logic       last_of_line;

    frame_state_t pred_state = FS_IDLE;
    int           pred_fill  = 0;
    logic [7:0]   pred_store [LINE_BYTES];
    line_item_t   expected_bytes [$];
    line_item_t   got_item;

    int send_idle_pct = 36;
    int recv_idle_pct = 53;
    int hold_request  = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int quiet_cycles  = 0;
    int mismatches    = 0;

    at_response_line_framer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .line_byte   (line_byte),
        .line_kind   (line_kind),
        .last_of_line(last_of_line)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic store_byte(input logic [7:0] b);
        if (pred_fill < LINE_BYTES)
        begin
            pred_store[pred_fill] = b;
            pred_fill++;
        end
    endtask

    task automatic begin_line(input logic [7:0] b, input frame_state_t next_state);
        pred_fill = 0;
        store_byte(b);
        pred_state = next_state;
    endtask

    task automatic predict_line_bytes(input logic [7:0] b);
        logic       term;
        logic       kind;
        line_item_t item;
        term = (b == CH_CR) || (b == CH_LF);
        case (pred_state)
            FS_IDLE:
            begin
                if (!term)
                begin
                    if (b == CH_PLUS)
                        begin_line(b, FS_AT);
                    else if (b == CH_A)
                        begin_line(b, FS_GOT_A);
                    else
                        begin_line(b, FS_APP);
                end
            end
            FS_GOT_A:
            begin
                if (b == CH_T)
                begin
                    store_byte(b);
                    pred_state = FS_AT;
                end
                else if (b == CH_PLUS)
                    begin_line(b, FS_AT);
                else
                begin
                    pred_fill  = 0;
                    pred_state = FS_IDLE;
                end
            end
            default:
            begin
                kind = (pred_state == FS_APP) ? KIND_APP : KIND_AT;
                if (pred_fill >= LINE_BYTES - 1)
                begin
                    pred_fill  = 0;
                    pred_state = FS_IDLE;
                end
                else if (term)
                begin
                    for (int i = 0; i < pred_fill; i++)
                    begin
                        item.data = pred_store[i];
                        item.kind = kind;
                        item.last = (i == pred_fill - 1);
                        expected_bytes.push_back(item);
                    end
                    pred_fill  = 0;
                    pred_state = FS_IDLE;
                end
                else
                    store_byte(b);
            end
        endcase
    endtask

    task automatic send_item(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        predict_line_bytes(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i]);
    endtask

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    task automatic send_random_line(input line_head_t head, input int body_len,
                                    input line_term_t term_sel);
        logic [7:0] b;
        case (head)
            HEAD_AT: send_text("AT");
            HEAD_PLUS: send_item(CH_PLUS);
            HEAD_A_PLUS: send_text("A+");
            HEAD_APP:
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == CH_CR || b == CH_LF || b == CH_PLUS || b == CH_A);
                send_item(b);
            end
            HEAD_A_JUNK:
            begin
                send_item(CH_A);
                do
                    b = 8'($urandom_range(255));
                while (b == CH_T || b == CH_PLUS);
                send_item(b);
            end
        endcase
        for (int i = 0; i < body_len; i++)
            send_item(body_byte());
        case (term_sel)
            TERM_CR: send_item(CH_CR);
            TERM_LF: send_item(CH_LF);
            TERM_CR_LF:
            begin
                send_item(CH_CR);
                send_item(CH_LF);
            end
            TERM_LF_CR:
            begin
                send_item(CH_LF);
                send_item(CH_CR);
            end
        endcase
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        send_text("AT\r");
        send_text("\r\n");
        send_text("+\n");
        send_text("A+K\r");
        send_text("Ax");
        send_text("A\n");
        send_text("AAT\r");
        send_item(8'h00);
        send_item(8'hFF);
        send_item(CH_CR);
        wait_drained();
    endtask

    task automatic test_line_limits();
        send_random_line(HEAD_AT, LINE_BYTES - 4, TERM_CR);
        send_random_line(HEAD_APP, LINE_BYTES - 1, TERM_LF);
        wait_drained();
    endtask

    task automatic test_random_lines(input int send_pct, input int recv_pct, input int target);
        int first;
        int body_len;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first = items_sent;
        while (items_sent - first < target)
        begin
            if ($urandom_range(9) == 0)
                send_item(8'($urandom_range(255)));
            else
            begin
                if ($urandom_range(15) == 0)
                    body_len = $urandom_range(LINE_BYTES - 2);
                else
                    body_len = $urandom_range(8);
                send_random_line(line_head_t'($urandom_range(4)), body_len,
                                 line_term_t'($urandom_range(3)));
            end
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 400;
        for (int n = 0; n < 4; n++)
            send_random_line(HEAD_APP, 6, TERM_CR);
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual byte %02h kind %0b last %0b",
                         $time, line_byte, line_kind, last_of_line);
                mismatches++;
            end
            else
            begin
                got_item = expected_bytes.pop_front();
                if (line_byte !== got_item.data)
                begin
                    $display("%0t: line_byte expected %02h, actual %02h",
                             $time, got_item.data, line_byte);
                    mismatches++;
                end
                if (line_kind !== got_item.kind)
                begin
                    $display("%0t: line_kind expected %0b, actual %0b",
                             $time, got_item.kind, line_kind);
                    mismatches++;
                end
                if (last_of_line !== got_item.last)
                begin
                    $display("%0t: last_of_line expected %0b, actual %0b",
                             $time, got_item.last, last_of_line);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb_at_response_line_framer: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_line_limits();
        test_random_lines(36, 53, 30);
        test_random_lines(53, 36, 30);
        test_random_lines(0, 0, 30);
        test_backpressure();
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("tb_at_response_line_framer: PASS");
        else
            $display("tb_at_response_line_framer: FAIL");
        $finish;
    end

endmodule
